/* src/lbm_pkg.sv */
// shared types, constants and helpers for the d2q9 collide and stream block
`default_nettype none

package lbm_pkg;

    localparam int DEF_MAX_X      = 256;
    localparam int DEF_MAX_Y      = 256;
    localparam int NUM_DIRECTIONS = 9;
    localparam int CFG_W          = 9;
    localparam int CFG_IDX_W      = 2;
    localparam int QW             = 26;
    localparam int DEN_W          = 25;
    localparam int REM_W          = 26;
    localparam int MAG_W          = 33;
    localparam int SUM_W          = 33;
    localparam int PROD_W         = MAG_W + QW;
    localparam int IN_TDATA_W     = 240;
    localparam int OUT_TDATA_W    = 88;

    localparam logic [REM_W-1:0] REM_INIT = REM_W'(1) << (40 - QW);
    localparam logic [DEN_W-1:0] HALF_Q16 = DEN_W'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_PERIODIC_X  = 2'd2,
        REG_PERIODIC_Y  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_OBSTACLE = 1'b0,
        OP_ELEMENT  = 1'b1
    } op_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] pos;
    } axis_t;

    typedef struct packed {
        logic [7:0]              nx;
        logic [7:0]              ny;
        logic [3:0]              dir;
        logic [MAG_W-1:0]        g_mag;
        logic                    g_neg;
        logic signed [SUM_W-1:0] g_sum;
        logic [MAG_W-1:0]        h_mag;
        logic                    h_neg;
        logic signed [SUM_W-1:0] h_sum;
        logic [DEN_W-1:0]        den;
        logic [REM_W-1:0]        rem;
        logic [QW-1:0]           quot;
    } pipe_t;

    function automatic logic signed [1:0] vel_x(input logic [3:0] d);
        logic signed [1:0] v;
        case (d) inside
            4'd1, 4'd5, 4'd8: v = 2'sd1;
            4'd3, 4'd6, 4'd7: v = -2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] vel_y(input logic [3:0] d);
        logic signed [1:0] v;
        case (d) inside
            4'd2, 4'd5, 4'd6: v = 2'sd1;
            4'd4, 4'd7, 4'd8: v = -2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic axis_t move_axis(input logic [7:0] pos, input logic signed [1:0] dv,
                                        input logic [8:0] size, input logic wrap);
        logic signed [9:0] n;
        axis_t             a;
        n = $signed({2'b00, pos}) + 10'(dv);
        if (n < 0 || n >= $signed({1'b0, size})) begin
            a.ok  = wrap;
            a.pos = (n < 0) ? 8'(size - 9'd1) : 8'd0;
        end else begin
            a.ok  = 1'b1;
            a.pos = n[7:0];
        end
        return a;
    endfunction

endpackage

`default_nettype wire

/* src/lbm_d2q9_collide_stream.sv */
// d2q9 bgk collide and stream element unit with obstacle map memory
//
//  channel | dir | handshake         | contents
//  s_      | in  | tvalid/tready     | tuser operation, tdata element or obstacle write
//  m_      | out | tvalid/tready     | tdata streamed element
//  cfg_    | in  | cfg_wr_en         | grid size and periodic flags
//
// one item per cycle sustained while m_tready is high; from accept to m_tvalid an item passes the
// obstacle read, load stage, 26-stage restoring reciprocal pipeline, multiply and
// round/saturate stages
// after reset a clearing pass over all MAX_X*MAX_Y addresses zeroes the obstacle map, s_tready low
// a stall on m_tready freezes the whole pipeline; s_tready follows it
`default_nettype none

module lbm_d2q9_collide_stream
    import lbm_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // node_x, node_y, direction, obstacle_flag, g_in, g_eq, g_source,
    // h_in, h_eq, h_source, relax_time, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // operation
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // dest_x, dest_y, dest_direction, g_out, h_out, zero pad
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int DEPTH = MAX_X * MAX_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int LIM_X = (MAX_X < 256) ? MAX_X : 256;
    localparam int LIM_Y = (MAX_Y < 256) ? MAX_Y : 256;

    logic [8:0] grid_w_reg, grid_h_reg;
    logic       per_x_reg, per_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg <= 9'd256;
            grid_h_reg <= 9'd256;
            per_x_reg  <= 1'b0;
            per_y_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:  grid_w_reg <= cfg_data;
                REG_GRID_HEIGHT: grid_h_reg <= cfg_data;
                REG_PERIODIC_X:  per_x_reg  <= cfg_data[0];
                REG_PERIODIC_Y:  per_y_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clearing pass
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    logic out_valid_reg;
    logic en;
    logic accept;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en && !clr_busy_reg;
    assign accept   = s_tvalid && s_tready;

    // input unpack
    logic [7:0]  in_x, in_y;
    logic [3:0]  in_dir;
    logic        in_flag;
    logic [31:0] in_g_in, in_g_eq, in_g_src, in_h_in, in_h_eq, in_h_src;
    logic [23:0] in_tau;

    assign in_x     = s_tdata[7:0];
    assign in_y     = s_tdata[15:8];
    assign in_dir   = s_tdata[19:16];
    assign in_flag  = s_tdata[20];
    assign in_g_in  = s_tdata[52:21];
    assign in_g_eq  = s_tdata[84:53];
    assign in_g_src = s_tdata[116:85];
    assign in_h_in  = s_tdata[148:117];
    assign in_h_eq  = s_tdata[180:149];
    assign in_h_src = s_tdata[212:181];
    assign in_tau   = s_tdata[236:213];

    // grid limits and streaming target
    logic [8:0]    w_eff, h_eff;
    axis_t         ax, ay;
    logic          elem_ok;
    logic          obs_wr;
    logic [AW-1:0] src_addr, dst_addr, wr_addr;
    logic          ram_we, ram_wd;

    always_comb begin
        if (grid_w_reg == 9'd0) begin
            w_eff = 9'd1;
        end else if (grid_w_reg > 9'(LIM_X)) begin
            w_eff = 9'(LIM_X);
        end else begin
            w_eff = grid_w_reg;
        end
        if (grid_h_reg == 9'd0) begin
            h_eff = 9'd1;
        end else if (grid_h_reg > 9'(LIM_Y)) begin
            h_eff = 9'(LIM_Y);
        end else begin
            h_eff = grid_h_reg;
        end
        ax = move_axis(in_x, vel_x(in_dir), w_eff, per_x_reg);
        ay = move_axis(in_y, vel_y(in_dir), h_eff, per_y_reg);
        elem_ok = ({1'b0, in_x} < w_eff) && ({1'b0, in_y} < h_eff)
                  && (in_dir < 4'(NUM_DIRECTIONS)) && ax.ok && ay.ok;
        obs_wr = accept && (op_t'(s_tuser) == OP_OBSTACLE)
                 && (32'(in_x) < 32'(MAX_X)) && (32'(in_y) < 32'(MAX_Y));
        src_addr = AW'(in_x) + AW'(in_y) * AW'(MAX_X);
        dst_addr = AW'(ax.pos) + AW'(ay.pos) * AW'(MAX_X);
        if (clr_busy_reg) begin
            ram_we  = 1'b1;
            ram_wd  = 1'b0;
            wr_addr = clr_addr_reg;
        end else begin
            ram_we  = obs_wr;
            ram_wd  = in_flag;
            wr_addr = src_addr;
        end
    end

    logic src_obs, dst_obs;

    lbm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_obs_src (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (ram_wd),
        .re    (en),
        .raddr (src_addr),
        .rdata (src_obs)
    );

    lbm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_obs_dst (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (ram_wd),
        .re    (en),
        .raddr (dst_addr),
        .rdata (dst_obs)
    );

    // stage a: aligned with obstacle reads
    logic                    a_valid_reg;
    logic [7:0]              a_nx_reg, a_ny_reg;
    logic [3:0]              a_dir_reg;
    logic signed [31:0]      a_g_in_reg, a_g_eq_reg, a_g_src_reg;
    logic signed [31:0]      a_h_in_reg, a_h_eq_reg, a_h_src_reg;
    logic [DEN_W-1:0]        a_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= accept && (op_t'(s_tuser) == OP_ELEMENT) && elem_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_nx_reg    <= ax.pos;
            a_ny_reg    <= ay.pos;
            a_dir_reg   <= in_dir;
            a_g_in_reg  <= in_g_in;
            a_g_eq_reg  <= in_g_eq;
            a_g_src_reg <= in_g_src;
            a_h_in_reg  <= in_h_in;
            a_h_eq_reg  <= in_h_eq;
            a_h_src_reg <= in_h_src;
            a_den_reg   <= DEN_W'(in_tau) + HALF_Q16;
        end
    end

    // reciprocal pipeline
    pipe_t pipe_reg   [0:QW];
    logic  pvalid_reg [0:QW];
    pipe_t pipe_next  [0:QW];

    always_comb begin
        logic signed [SUM_W-1:0] gd, hd;
        logic [REM_W-1:0]        r2;
        gd = SUM_W'(a_g_in_reg) - SUM_W'(a_g_eq_reg);
        hd = SUM_W'(a_h_in_reg) - SUM_W'(a_h_eq_reg);
        pipe_next[0].nx    = a_nx_reg;
        pipe_next[0].ny    = a_ny_reg;
        pipe_next[0].dir   = a_dir_reg;
        pipe_next[0].g_neg = gd[SUM_W-1];
        pipe_next[0].g_mag = gd[SUM_W-1] ? MAG_W'(-gd) : MAG_W'(gd);
        pipe_next[0].g_sum = SUM_W'(a_g_in_reg) + SUM_W'(a_g_src_reg);
        pipe_next[0].h_neg = hd[SUM_W-1];
        pipe_next[0].h_mag = hd[SUM_W-1] ? MAG_W'(-hd) : MAG_W'(hd);
        pipe_next[0].h_sum = SUM_W'(a_h_in_reg) + SUM_W'(a_h_src_reg);
        pipe_next[0].den   = a_den_reg;
        pipe_next[0].rem   = REM_INIT;
        pipe_next[0].quot  = '0;
        for (int k = 0; k < QW; k++) begin
            pipe_next[k+1] = pipe_reg[k];
            r2 = {pipe_reg[k].rem[REM_W-2:0], 1'b0};
            if (r2 >= REM_W'(pipe_reg[k].den)) begin
                pipe_next[k+1].rem  = r2 - REM_W'(pipe_reg[k].den);
                pipe_next[k+1].quot = {pipe_reg[k].quot[QW-2:0], 1'b1};
            end else begin
                pipe_next[k+1].rem  = r2;
                pipe_next[k+1].quot = {pipe_reg[k].quot[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QW; k++) begin
                pvalid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            pvalid_reg[0] <= a_valid_reg && !src_obs && !dst_obs;
            for (int k = 0; k < QW; k++) begin
                pvalid_reg[k+1] <= pvalid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= QW; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // multiply stage
    logic                    mul_valid_reg;
    logic [PROD_W-1:0]       mul_g_prod_reg, mul_h_prod_reg;
    logic                    mul_g_neg_reg, mul_h_neg_reg;
    logic signed [SUM_W-1:0] mul_g_sum_reg, mul_h_sum_reg;
    logic [7:0]              mul_nx_reg, mul_ny_reg;
    logic [3:0]              mul_dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= pvalid_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_g_prod_reg <= PROD_W'(pipe_reg[QW].g_mag) * PROD_W'(pipe_reg[QW].quot);
            mul_h_prod_reg <= PROD_W'(pipe_reg[QW].h_mag) * PROD_W'(pipe_reg[QW].quot);
            mul_g_neg_reg  <= pipe_reg[QW].g_neg;
            mul_h_neg_reg  <= pipe_reg[QW].h_neg;
            mul_g_sum_reg  <= pipe_reg[QW].g_sum;
            mul_h_sum_reg  <= pipe_reg[QW].h_sum;
            mul_nx_reg     <= pipe_reg[QW].nx;
            mul_ny_reg     <= pipe_reg[QW].ny;
            mul_dir_reg    <= pipe_reg[QW].dir;
        end
    end

    function automatic logic [31:0] finish(input logic [PROD_W-1:0] prod, input logic neg,
                                           input logic signed [SUM_W-1:0] sum);
        logic [PROD_W:0]    rnd;
        logic [35:0]        q;
        logic signed [37:0] qs;
        logic signed [37:0] r;
        logic [31:0]        res;
        rnd = {1'b0, prod} + (PROD_W+1)'(1 << 23);
        q   = 36'(rnd >> 24);
        qs  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        r   = 38'(sum) - qs;
        if (r > 38'sd2147483647) begin
            res = 32'h7fff_ffff;
        end else if (r < -38'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = r[31:0];
        end
        return res;
    endfunction

    logic [OUT_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {4'd0,
                             finish(mul_h_prod_reg, mul_h_neg_reg, mul_h_sum_reg),
                             finish(mul_g_prod_reg, mul_g_neg_reg, mul_g_sum_reg),
                             mul_dir_reg, mul_ny_reg, mul_nx_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* src/lbm_ram.sv */
// generic single write port ram with one registered read port
`default_nettype none

module lbm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/lbm_checker.sv */
// port-level checks for the collide and stream block and their bind
`default_nettype none

module lbm_checker
    import lbm_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during obstacle clearing");

    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:16] < 4'(NUM_DIRECTIONS))
        else $error("result item with invalid direction");

endmodule

bind lbm_d2q9_collide_stream lbm_checker u_lbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
